FILE: design/demand_page_fault_mapper_top_macros.svh
// Assertion macros used by the top-level design file.
// Define NO_ASSERTIONS to compile them away.
`ifndef DEMAND_PAGE_FAULT_MAPPER_TOP_MACROS_SVH
`define DEMAND_PAGE_FAULT_MAPPER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define DPFM_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("dpfm assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define DPFM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("dpfm assertion failed");
`else
`define DPFM_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define DPFM_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: design/dpfm_pkg.sv
`timescale 1ns / 1ps
package dpfm_pkg;

  localparam int VA_W            = 48;
  localparam int PAGE_SHIFT      = 12;
  localparam int PAGE_W          = 36;
  localparam int CNT_W           = 32;
  localparam int USED_W          = 10;
  localparam int PAGES_PER_BLOCK = 512;

  localparam logic [PAGE_W-1:0]     WINDOW_BASE_RST = 36'h0_0080_0000;
  localparam logic [PAGE_SHIFT-1:0] LEAF_BITS       = 12'h407;

  // Configuration register indexes.
  localparam logic CFG_WINDOW_BASE = 1'b0;
  localparam logic CFG_POOL_BASE   = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef enum logic [1:0] {
    STAT_OUTSIDE = 2'd0,
    STAT_MAPPED  = 2'd1,
    STAT_PRESENT = 2'd2,
    STAT_OOM     = 2'd3
  } status_t;

  typedef struct packed {
    logic mapped;
    logic oom;
  } alloc_cmd_t;

endpackage

FILE: design/dpfm_bitmap.sv
`timescale 1ns / 1ps
module dpfm_bitmap #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                     rd_bit,
  input  logic                     set_en,
  input  logic [$clog2(DEPTH)-1:0] set_addr,
  output logic                     clear_done
);
  import dpfm_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic             mem [DEPTH];
  logic             rd_bit_r;
  logic [AW-1:0]    clr_ptr_r, clr_ptr_nxt;
  logic             clearing_r, clearing_nxt;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             wr_data;

  // The sweep writes zero to one entry per cycle after reset.
  always_comb begin
    clr_ptr_nxt  = clr_ptr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_ptr_nxt = clr_ptr_r + AW'(1);
      if (clr_ptr_r == AW'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r  <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_ptr_r  <= clr_ptr_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  assign wr_en   = clearing_r || set_en;
  assign wr_addr = clearing_r ? clr_ptr_r : set_addr;
  assign wr_data = !clearing_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_bit_r <= mem[rd_addr];
    end
  end

  assign rd_bit     = rd_bit_r;
  assign clear_done = !clearing_r;

endmodule

FILE: design/dpfm_alloc.sv
`timescale 1ns / 1ps
module dpfm_alloc #(
  parameter int POOL_FRAMES = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dpfm_pkg::alloc_cmd_t              cmd,
  output logic [$clog2(POOL_FRAMES+1)-1:0]  next_frame,
  output logic                              pool_empty,
  output logic [dpfm_pkg::USED_W-1:0]       frames_used,
  output logic [dpfm_pkg::CNT_W-1:0]        map_count,
  output logic [dpfm_pkg::CNT_W-1:0]        oom_count
);
  import dpfm_pkg::*;

  localparam int FW = $clog2(POOL_FRAMES + 1);

  logic [FW-1:0]        next_frame_r, next_frame_nxt;
  logic [CNT_W-1:0]     map_r, map_nxt;
  logic [CNT_W-1:0]     oom_r, oom_nxt;
  logic [FW+USED_W-1:0] used_ext;

  always_comb begin
    next_frame_nxt = next_frame_r;
    map_nxt        = map_r;
    oom_nxt        = oom_r;
    if (cmd.mapped) begin
      next_frame_nxt = next_frame_r + FW'(1);
      map_nxt        = map_r + CNT_W'(1);
    end
    if (cmd.oom) begin
      oom_nxt = oom_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_frame_r <= '0;
      map_r        <= '0;
      oom_r        <= '0;
    end else begin
      next_frame_r <= next_frame_nxt;
      map_r        <= map_nxt;
      oom_r        <= oom_nxt;
    end
  end

  assign used_ext    = {{USED_W{1'b0}}, next_frame_r};
  assign next_frame  = next_frame_r;
  assign pool_empty  = next_frame_r >= FW'(POOL_FRAMES);
  assign frames_used = used_ext[USED_W-1:0];
  assign map_count   = map_r;
  assign oom_count   = oom_r;

endmodule

FILE: design/demand_page_fault_mapper_top.sv
`timescale 1ns / 1ps
// Demand page fault mapper. Each fault beat (start while busy is low) has an
// accept step, which computes the page's slot in the demand window and reads its
// present bit from the bitmap memory, and a lookup step, which decides the
// outcome, writes the present bit back and updates the frame allocator. The
// result beat appears on the out_ ports, marked by out_valid, in the cycle after
// the lookup step, and stays for exactly one cycle; the receiver cannot stall
// it, so it must take every result beat as it comes. The read-modify-write of
// the bitmap sets the rate: busy is high in the lookup step, so a new fault is
// accepted only once the last one is decided. After reset a sweep clears the
// bitmap, one entry per cycle; busy stays high for the sweep and until the FSM
// has left its clear state. Configuration writes are taken at any time, but
// should only be issued while no fault is in flight.
module demand_page_fault_mapper_top #(
  parameter int WINDOW_BLOCKS = 2,
  parameter int POOL_FRAMES   = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dpfm_pkg::VA_W-1:0]     in_fault_va,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_retry,
  output logic [dpfm_pkg::VA_W-1:0]     out_page_entry,
  output logic [dpfm_pkg::USED_W-1:0]   out_frames_used,
  output logic [dpfm_pkg::CNT_W-1:0]    out_fault_total,
  output logic [dpfm_pkg::CNT_W-1:0]    out_oom_total,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [dpfm_pkg::PAGE_W-1:0]   cfg_wdata
);
  import dpfm_pkg::*;
`include "demand_page_fault_mapper_top_macros.svh"

  localparam int WIN_PAGES = WINDOW_BLOCKS * PAGES_PER_BLOCK;
  localparam int SLOT_W    = $clog2(WIN_PAGES);
  localparam int FW        = $clog2(POOL_FRAMES + 1);

  // Configuration registers.
  logic [PAGE_W-1:0] window_base_r, window_base_nxt;
  logic [PAGE_W-1:0] pool_base_r, pool_base_nxt;

  always_comb begin
    window_base_nxt = window_base_r;
    pool_base_nxt   = pool_base_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_BASE: window_base_nxt = cfg_wdata;
        CFG_POOL_BASE:   pool_base_nxt   = cfg_wdata;
        default:         window_base_nxt = window_base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_base_r <= WINDOW_BASE_RST;
      pool_base_r   <= '0;
    end else begin
      window_base_r <= window_base_nxt;
      pool_base_r   <= pool_base_nxt;
    end
  end

  // Control state.
  state_t state_r, state_nxt;
  logic   accept;
  logic   clear_done;

  // Window test in the accept cycle. The subtraction carries a borrow bit, so a
  // page below the window base never aliases into the window.
  logic [PAGE_W-1:0] page;
  logic [PAGE_W:0]   diff;
  logic              in_win;
  logic [SLOT_W-1:0] slot;
  logic              in_win_r;
  logic [SLOT_W-1:0] slot_r;

  assign page   = in_fault_va[VA_W-1:PAGE_SHIFT];
  assign diff   = {1'b0, page} - {1'b0, window_base_r};
  assign in_win = !diff[PAGE_W] && (diff[PAGE_W-1:0] < PAGE_W'(WIN_PAGES));
  assign slot   = diff[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      in_win_r <= in_win;
      slot_r   <= slot;
    end
  end

  // Present bitmap and frame allocator.
  logic          present;
  logic          set_en;
  alloc_cmd_t    cmd;
  logic [FW-1:0] next_frame;
  logic          pool_empty;

  dpfm_bitmap #(
    .DEPTH (WIN_PAGES)
  ) u_bitmap (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr    (slot),
    .rd_bit     (present),
    .set_en     (set_en),
    .set_addr   (slot_r),
    .clear_done (clear_done)
  );

  dpfm_alloc #(
    .POOL_FRAMES (POOL_FRAMES)
  ) u_alloc (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .next_frame  (next_frame),
    .pool_empty  (pool_empty),
    .frames_used (out_frames_used),
    .map_count   (out_fault_total),
    .oom_count   (out_oom_total)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clear_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decision in the lookup cycle, once the present bit is back from memory.
  status_t           status;
  logic [PAGE_W-1:0] frame;
  logic              lookup;

  assign frame = pool_base_r + PAGE_W'(next_frame);

  always_comb begin
    lookup = 1'b0;
    busy   = 1'b1;
    unique case (state_r)
      ST_CLEAR:  busy = 1'b1;
      ST_IDLE:   busy = !rst_n;
      ST_LOOKUP: lookup = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  assign accept = start && !busy;

  always_comb begin
    if (!in_win_r) begin
      status = STAT_OUTSIDE;
    end else if (present) begin
      status = STAT_PRESENT;
    end else if (pool_empty) begin
      status = STAT_OOM;
    end else begin
      status = STAT_MAPPED;
    end
  end

  assign set_en     = lookup && (status == STAT_MAPPED);
  assign cmd.mapped = set_en;
  assign cmd.oom    = lookup && (status == STAT_OOM);

  // Result registers; the counters in the allocator change at the same edge,
  // so they already hold the post-fault values while out_valid is high.
  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic            out_retry_r;
  logic [VA_W-1:0] out_page_entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      out_status_r     <= status;
      out_retry_r      <= (status == STAT_MAPPED) || (status == STAT_PRESENT);
      out_page_entry_r <= (status == STAT_MAPPED) ? {frame, LEAF_BITS} : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_retry      = out_retry_r;
  assign out_page_entry = out_page_entry_r;

  // A lookup always produces exactly one result beat in the next cycle.
  `DPFM_ASSERT_NEXT(a_lookup_gives_result, clk, rst_n, state_r == ST_LOOKUP, out_valid_r)
  // An accepted fault always moves to the lookup cycle.
  `DPFM_ASSERT_NEXT(a_accept_to_lookup, clk, rst_n, accept, state_r == ST_LOOKUP)
  // Only a newly mapped page carries a descriptor.
  `DPFM_ASSERT_NOW(a_entry_only_mapped, clk, rst_n,
                   out_valid_r && (out_status_r != STAT_MAPPED), out_page_entry_r == '0)
  // Allocating a frame never happens while the pool is exhausted.
  `DPFM_ASSERT_NOW(a_no_alloc_when_empty, clk, rst_n, set_en, !pool_empty && in_win_r)
  // The bitmap is never written by a fault while the clearing sweep runs.
  `DPFM_ASSERT_NOW(a_no_set_during_clear, clk, rst_n, !clear_done, !set_en && !accept)

endmodule
